@@ src/obf_pkg.sv @@
// Package for the offset bitmap filter: action codes, status codes, register
// indexes and the control group that drives the bitmap store. No dependencies.
package obf_pkg;

   typedef enum logic [1:0] {
      ACT_MEASURE = 2'd0,
      ACT_INSERT  = 2'd1,
      ACT_PROBE   = 2'd2,
      ACT_BUILD   = 2'd3
   } action_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_WIDTH = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_VALUE_BYTES = 2'd0;
   localparam logic [1:0] CSR_USE_OFFSET  = 2'd1;
   localparam logic [1:0] CSR_BIT_LIMIT   = 2'd2;

   localparam int WORD_BITS = 64;

   // Control for one cycle of the bitmap store.
   typedef struct packed {
      logic       rd_en;    // read word at addr into the read register
      logic       set_en;   // write back read word with bit_sel set
      logic       clr_en;   // write zero to the word at addr
      logic [5:0] bit_sel;  // bit within the word
   } bm_ctrl_type;

endpackage

@@ src/obf_bitmap.sv @@
// Bitmap store of the offset bitmap filter: one synchronous single-port memory
// of 64-bit words with a registered read and a set-bit write back. Uses obf_pkg.
module obf_bitmap #(
   parameter int WORDS = 1024,
   parameter int AW    = 10
) (
   input  logic                clock,
   input  obf_pkg::bm_ctrl_type ctrl,
   input  logic [AW-1:0]       addr,
   output logic                hit
);
   import obf_pkg::*;

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
      if (ctrl.clr_en) begin
         mem[addr] <= '0;
      end else if (ctrl.set_en) begin
         mem[addr] <= rd_data_ff | (WORD_BITS'(1) << ctrl.bit_sel);
      end
   end

   // bit of the last word read
   assign hit = rd_data_ff[ctrl.bit_sel];

endmodule

@@ src/offset_bitmap_filter_top.sv @@
// Top level of the offset bitmap filter: control sequencer, key range logic
// and response register. Uses obf_pkg and instantiates obf_bitmap.
//
// Dense bitmap membership filter for join key filtering. Each item gives one
// response item. A start-build item resets the running minimum and maximum and
// drops any built filter. Feed the key column once with the measure action
// (mark the final key with last), then once more with the insert action; probe
// items then answer hit for keys that fall inside [base, base + bit_count) and
// whose bit is set. Status is non-zero only on the response to the last measure
// item: 1 for a key width other than 1, 2, 4 or 8 bytes, 2 for a span that
// reaches the bit limit; after such a failure every probe answers 0. The block
// works on one item at a time and its state lives in a single-port bitmap
// memory of MAP_BITS/64 words with a registered read. A measure or start-build
// item is handled in the execute step; an insert or probe item first reads
// the word, then tests or writes it back; a last measure item passes
// through a fix step and, on a successful non-empty build, a clearing pass
// that zeroes the words in range; req_stall stays high through it. The
// response waits in its own register, so a stalled response does not hold
// off acceptance of the next item, only its processing. Write the
// configuration registers only while the block is idle.
module offset_bitmap_filter_top #(
   parameter int MAP_BITS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_key_value,
   input  logic        req_is_null,
   input  logic        req_last,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [1:0]  rsp_status
);
   import obf_pkg::*;

   localparam int WORDS = (MAP_BITS / WORD_BITS > 0) ? MAP_BITS / WORD_BITS : 1;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW    = $clog2(MAP_BITS + 1);      // bit count width
   localparam int LIMW  = (CW > 17) ? CW : 17;       // limit compare width
   localparam logic [CW-7:0]   WORD_LAST = (CW - 6)'(WORDS - 1);
   localparam logic [LIMW-1:0] MAX_LIM   = LIMW'(MAP_BITS);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_READ  = 5'b00100,
      S_FIX   = 5'b01000,
      S_CLEAR = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [3:0]  vbytes_ff;
   logic        offset_ff;
   logic [16:0] limit_ff;

   // item in hand
   action_type  act_ff;
   logic [63:0] key_ff;
   logic        null_ff, last_ff;

   // filter state
   logic [63:0]   min_ff, min_in, max_ff, max_in, base_ff, base_in;
   logic          seen_ff, seen_in, built_ff, built_in;
   logic [CW-1:0] count_ff, count_in;

   // bitmap access
   logic [AW-1:0] addr_ff, addr_in, clr_addr_ff, clr_addr_in, clr_last_ff, clr_last_in;
   logic [5:0]    bit_ff, bit_in;
   logic          inrange_ff, inrange_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   bm_ctrl_type   bm_ctrl;
   logic [AW-1:0] bm_addr;
   logic          bm_hit;

   logic        out_free, emit, accept;
   logic [63:0] key_masked;

   // range arithmetic
   logic [64:0]     diff;
   logic [CW-7:0]   diff_word;
   logic            idx_ok;
   logic [63:0]     base_sel, span;
   logic [LIMW-1:0] lim_cap;
   logic            over, width_ok;
   logic [CW-7:0]   span_word;

   // keep the low value_bytes bytes; above 8 keeps all, 0 keeps none
   function automatic logic [63:0] mask_key(input logic [63:0] k, input logic [3:0] nb);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (nb > 4'(b)) begin
            m[b*8 +: 8] = k[b*8 +: 8];
         end
      end
      return m;
   endfunction

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign key_masked = mask_key(req_key_value, vbytes_ff);

   // insert / probe index: key minus base, checked against the fixed range
   assign diff      = {1'b0, key_ff} - {1'b0, base_ff};
   assign diff_word = diff[CW-1:6];
   assign idx_ok    = built_ff && !null_ff && !diff[64] && (diff[63:CW] == '0)
                      && (diff[CW-1:0] < count_ff) && (diff_word <= WORD_LAST);

   // build: base, span and limit check
   assign base_sel = (offset_ff && seen_ff) ? min_ff : 64'd0;
   assign span     = seen_ff ? (max_ff - base_sel) : 64'd0;
   assign lim_cap  = (LIMW'(limit_ff) < MAX_LIM) ? LIMW'(limit_ff) : MAX_LIM;
   assign over     = (span[63:LIMW] != '0) || (span[LIMW-1:0] >= lim_cap);
   assign width_ok = (vbytes_ff == 4'd1) || (vbytes_ff == 4'd2) ||
                     (vbytes_ff == 4'd4) || (vbytes_ff == 4'd8);
   assign span_word = (span[CW-1:6] > WORD_LAST) ? WORD_LAST : span[CW-1:6];

   always_comb begin
      state_in      = state_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      seen_in       = seen_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      built_in      = built_ff;
      addr_in       = addr_ff;
      bit_in        = bit_ff;
      inrange_in    = inrange_ff;
      clr_addr_in   = clr_addr_ff;
      clr_last_in   = clr_last_ff;
      emit          = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      bm_ctrl       = '{rd_en: 1'b0, set_en: 1'b0, clr_en: 1'b0, bit_sel: bit_ff};
      bm_addr       = addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               unique case (act_ff)
                  ACT_BUILD: begin
                     // drop the filter; the bitmap is cleared when the next range is fixed
                     min_in   = '0;
                     max_in   = '0;
                     seen_in  = 1'b0;
                     base_in  = '0;
                     count_in = '0;
                     built_in = 1'b0;
                     emit          = 1'b1;
                     rsp_hit_in    = 1'b0;
                     rsp_status_in = ST_OK;
                     state_in      = S_IDLE;
                  end
                  ACT_MEASURE: begin
                     if (!null_ff) begin
                        seen_in = 1'b1;
                        if (!seen_ff || key_ff < min_ff) min_in = key_ff;
                        if (!seen_ff || key_ff > max_ff) max_in = key_ff;
                     end
                     if (last_ff) begin
                        state_in = S_FIX;
                     end else begin
                        emit          = 1'b1;
                        rsp_hit_in    = 1'b0;
                        rsp_status_in = ST_OK;
                        state_in      = S_IDLE;
                     end
                  end
                  default: begin
                     // insert or probe: read the word, act on it in S_READ
                     bm_ctrl.rd_en   = 1'b1;
                     bm_ctrl.bit_sel = diff[5:0];
                     bm_addr         = diff_word[AW-1:0];
                     addr_in         = diff_word[AW-1:0];
                     bit_in          = diff[5:0];
                     inrange_in      = idx_ok;
                     state_in        = S_READ;
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               bm_ctrl.set_en = (act_ff == ACT_INSERT) && inrange_ff;
               emit           = 1'b1;
               rsp_hit_in     = (act_ff == ACT_PROBE) && inrange_ff && bm_hit;
               rsp_status_in  = ST_OK;
               state_in       = S_IDLE;
            end
         end
         S_FIX: begin
            if (out_free) begin
               emit       = 1'b1;
               rsp_hit_in = 1'b0;
               base_in    = '0;
               count_in   = '0;
               built_in   = 1'b0;
               state_in   = S_IDLE;
               priority if (!width_ok) begin
                  rsp_status_in = ST_BAD_WIDTH;
               end else if (seen_ff && over) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  rsp_status_in = ST_OK;
                  base_in       = base_sel;
                  built_in      = 1'b1;
                  if (seen_ff) begin
                     // span is below the limit, so span + 1 fits the count
                     count_in    = span[CW-1:0] + CW'(1);
                     clr_addr_in = '0;
                     clr_last_in = span_word[AW-1:0];
                     state_in    = S_CLEAR;
                  end
               end
            end
         end
         S_CLEAR: begin
            // zero the words the new range covers, one a cycle
            bm_ctrl.clr_en = 1'b1;
            bm_addr        = clr_addr_ff;
            if (clr_addr_ff == clr_last_ff) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vbytes_ff    <= 4'd8;
         offset_ff    <= 1'b1;
         limit_ff     <= 17'd65536;
         min_ff       <= '0;
         max_ff       <= '0;
         seen_ff      <= 1'b0;
         base_ff      <= '0;
         count_ff     <= '0;
         built_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         seen_ff      <= seen_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         built_ff     <= built_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_VALUE_BYTES: vbytes_ff <= csr_wr_data[3:0];
               CSR_USE_OFFSET:  offset_ff <= csr_wr_data[0];
               CSR_BIT_LIMIT:   limit_ff  <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= action_type'(req_action);
         key_ff  <= key_masked;
         null_ff <= req_is_null;
         last_ff <= req_last;
      end
      addr_ff       <= addr_in;
      bit_ff        <= bit_in;
      inrange_ff    <= inrange_in;
      clr_addr_ff   <= clr_addr_in;
      clr_last_ff   <= clr_last_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
   end

   obf_bitmap #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_bitmap (
      .clock (clock),
      .ctrl  (bm_ctrl),
      .addr  (bm_addr),
      .hit   (bm_hit)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ test/tb_offset_bitmap_filter_top.sv @@
`timescale 1ns / 100ps
// Testbench for offset_bitmap_filter_top: directed table, then random build and noise sessions
// under twelve register settings, checked against a behavioural filter predictor.
// Depends on obf_pkg and the offset_bitmap_filter_top RTL; needs nothing else.
module tb_offset_bitmap_filter_top;
   import obf_pkg::*;

   localparam int          CLK_PERIOD    = 12;
   localparam int          RESET_CYCLES  = 7;
   localparam int          MAP_BITS      = 65536;
   localparam int          PHASE_ITEMS   = 120;
   localparam int          SETTLE_CYCLES = 1100;  // longest clearing pass plus margin
   localparam int          LONG_HOLD     = 400;
   localparam longint      WATCHDOG_NS   = 64'd10_000_000 * CLK_PERIOD;
   localparam logic [63:0] K_TOP         = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] K_LOW         = 64'hFFFF_FFFF_FFFF_FF80;
   localparam logic [63:0] K_MID         = K_LOW + 64'd16;

   // unused register index; writes to it must change nothing
   localparam logic [1:0] REG_SPARE = 2'd3;

   // One request item, with an optional typed-in answer.
   typedef struct packed {
      action_type  act;
      logic [63:0] key;
      logic        nul;
      logic        tail;
      logic        typed;
      logic        hit;
      logic [1:0]  status;
   } plan_row_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] status;
   } filter_answer_type;

   typedef struct packed {
      logic [3:0]  vb;
      logic        uo;
      logic [16:0] lim;
   } setting_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_index   = CSR_VALUE_BYTES;
   logic [16:0] csr_wr_data = '0;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [63:0] req_key_value;
   logic        req_is_null;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_hit;
   logic [1:0]  rsp_status;

   plan_row_type cur_row = '0;

   assign req_action    = cur_row.act;
   assign req_key_value = cur_row.key;
   assign req_is_null   = cur_row.nul;
   assign req_last      = cur_row.tail;

   offset_bitmap_filter_top #(.MAP_BITS(MAP_BITS)) dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_key_value(req_key_value),
      .req_is_null  (req_is_null),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit),
      .rsp_status   (rsp_status)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: registers, running min/max and the built filter.
   // Bitmap words only exist once set; a missing word reads as zero, which
   // mirrors the clearing pass that zeroes the words in range.
   // ---------------------------------------------------------------------
   logic [3:0]  cfg_bytes  = 4'd8;
   logic        cfg_offset = 1'b1;
   logic [16:0] cfg_limit  = 17'd65536;
   logic [63:0] run_min    = '0;
   logic [63:0] run_max    = '0;
   logic        run_seen   = 1'b0;
   logic [63:0] f_base     = '0;
   logic [63:0] f_count    = '0;
   logic        f_built    = 1'b0;
   logic [63:0] filter_words [int unsigned];

   filter_answer_type due_answers [$];
   int           mismatches  = 0;
   int           sent_items  = 0;
   int           quiet_send  = 0;
   int           quiet_recv  = 0;
   int           hold_asks   = 0;
   int           hold_served = 0;
   int           stall_left  = 0;
   int           open_left   = 0;

   // Zero-extend a raw key from the configured byte count; above 8 acts as 8.
   function automatic logic [63:0] masked_key(input logic [63:0] raw);
      int nb;
      nb = (cfg_bytes > 4'd8) ? 8 : int'(cfg_bytes);
      if (nb >= 8) return raw;
      return raw & ((64'd1 << (8 * nb)) - 64'd1);
   endfunction

   // Fill the bits above the key width with junk; the block must ignore them.
   function automatic logic [63:0] with_junk(input logic [63:0] k);
      return k | ({$urandom, $urandom} & ~masked_key('1));
   endfunction

   // Mostly short gaps, a few long ones, and now and then a quiet run of none.
   function automatic int draw_gap(inout int quiet_run);
      int r;
      if (quiet_run > 0) begin
         quiet_run--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         quiet_run = $urandom_range(20, 80);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Advance the filter by one item and work out its answer.
   task automatic filter_step(input action_type act, input logic [63:0] raw,
                              input logic nul, input logic tail,
                              output logic hit, output logic [1:0] st);
      logic [63:0] k, lo, span, lim, idx, word;
      int unsigned w;
      k   = masked_key(raw);
      hit = 1'b0;
      st  = ST_OK;
      case (act)
         ACT_BUILD: begin
            filter_words.delete();
            run_min  = '0;
            run_max  = '0;
            run_seen = 1'b0;
            f_base   = '0;
            f_count  = '0;
            f_built  = 1'b0;
         end
         ACT_MEASURE: begin
            if (!nul) begin
               if (!run_seen) begin
                  run_min  = k;
                  run_max  = k;
                  run_seen = 1'b1;
               end else begin
                  if (k < run_min) run_min = k;
                  if (k > run_max) run_max = k;
               end
            end
            // the last measure item fixes the range and empties the bitmap
            if (tail) begin
               lim  = (cfg_limit < MAP_BITS) ? 64'(cfg_limit) : 64'(MAP_BITS);
               lo   = (cfg_offset && run_seen) ? run_min : '0;
               span = run_seen ? run_max - lo : '0;
               filter_words.delete();
               f_built = 1'b0;
               f_base  = '0;
               f_count = '0;
               if (!(cfg_bytes inside {4'd1, 4'd2, 4'd4, 4'd8})) begin
                  st = ST_BAD_WIDTH;
               end else if (run_seen && span >= lim) begin
                  st = ST_RANGE;
               end else begin
                  f_base  = lo;
                  f_count = run_seen ? span + 64'd1 : '0;
                  f_built = 1'b1;
               end
            end
         end
         ACT_INSERT: begin
            if (f_built && !nul && k >= f_base && (k - f_base) < f_count) begin
               idx  = k - f_base;
               w    = 32'(idx >> 6);
               word = filter_words.exists(w) ? filter_words[w] : '0;
               word[idx[5:0]] = 1'b1;
               filter_words[w] = word;
            end
         end
         ACT_PROBE: begin
            if (f_built && !nul && k >= f_base && (k - f_base) < f_count) begin
               idx = k - f_base;
               w   = 32'(idx >> 6);
               if (filter_words.exists(w)) hit = filter_words[w][idx[5:0]];
            end
         end
         default: ;
      endcase
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // Monitor: track register writes, predict each accepted item and check
   // each accepted response against the oldest answer due.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic              p_hit;
      logic [1:0]        p_status;
      filter_answer_type due;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_VALUE_BYTES: cfg_bytes  = csr_wr_data[3:0];
               CSR_USE_OFFSET:  cfg_offset = csr_wr_data[0];
               CSR_BIT_LIMIT:   cfg_limit  = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            filter_step(cur_row.act, cur_row.key, cur_row.nul, cur_row.tail, p_hit, p_status);
            if (cur_row.typed) due_answers.push_back('{cur_row.hit, cur_row.status});
            else due_answers.push_back('{p_hit, p_status});
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_answers.size() == 0) begin
               note_mismatch("response with no item outstanding");
            end else begin
               due = due_answers.pop_front();
               if (rsp_hit !== due.hit)
                  note_mismatch($sformatf("hit %b, expected %b", rsp_hit, due.hit));
               if (rsp_status !== due.status)
                  note_mismatch($sformatf("status %0d, expected %0d", rsp_status, due.status));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall the response channel at random, and hold it off for a
   // long stretch whenever the stimulus asks for back-pressure.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         stall_left  = LONG_HOLD;
         open_left   = 0;
      end
      if (stall_left == 0 && open_left == 0) begin
         stall_left = draw_gap(quiet_recv);
         open_left  = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         open_left--;
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Sender tasks. Valid stays high from one item to the next when there is
   // no gap, so it is never lowered and raised in the same step.
   // ---------------------------------------------------------------------
   task automatic offer_item(input plan_row_type row);
      int gap;
      gap = draw_gap(quiet_send);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      cur_row   <= row;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   task automatic offer(input action_type act, input logic [63:0] key,
                        input logic nul, input logic tail);
      offer_item('{act, key, nul, tail, 1'b0, 1'b0, ST_OK});
   endtask

   // Drop valid and hold until every outstanding answer has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_answers.size() != 0) @(negedge clock);
   endtask

   // Write all three registers once the block is idle; a clearing pass may
   // still be running after the last response, so let it finish first.
   task automatic apply_setting(input setting_row_type s, input bit with_spare);
      logic [16:0] junk;
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      junk = 17'($urandom);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_VALUE_BYTES;
      csr_wr_data <= {junk[16:4], s.vb};
      @(negedge clock);
      csr_index   <= CSR_USE_OFFSET;
      csr_wr_data <= {junk[16:1], s.uo};
      @(negedge clock);
      csr_index   <= CSR_BIT_LIMIT;
      csr_wr_data <= s.lim;
      if (with_spare) begin
         @(negedge clock);
         csr_index   <= REG_SPARE;
         csr_wr_data <= ~junk;
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // A well-formed build: an optional start, measure pass, insert pass, then probes
   // around the edges of the fixed range.
   task automatic filter_session();
      logic [63:0] wmask, lim, spread, lo, hi, pick, tmp_key;
      logic [63:0] keys [$];
      logic        nuls [$];
      logic        tmp_nul;
      int          n, m, r, j;
      wmask = masked_key('1);
      lim   = (cfg_limit < MAP_BITS) ? 64'(cfg_limit) : 64'(MAP_BITS);
      r     = $urandom_range(0, 99);
      if (r < 60) spread = $urandom_range(0, 150);
      else if (r < 74) spread = $urandom_range(151, 3000);
      else if (r < 84) spread = (lim == 0) ? '0 : lim - 64'd1;  // just fits
      else if (r < 93) spread = lim;                              // just too wide
      else spread = {$urandom, $urandom};
      if (spread > wmask) spread = wmask;
      if (cfg_offset) begin
         lo = {$urandom, $urandom} & wmask;
         if (wmask - lo < spread) lo = wmask - spread;
         hi = lo + spread;
      end else begin
         // based at zero: the largest key alone decides the span
         hi = spread;
         lo = hi - (hi >> $urandom_range(0, 8));
      end
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         if (i == 0) pick = lo;
         else if (i == 1) pick = hi;
         else if (hi - lo == '1) pick = {$urandom, $urandom};
         else pick = lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
         keys.push_back(pick);
         nuls.push_back($urandom_range(0, 99) < 10);
      end
      // scatter the extremes through the column
      for (int i = 0; i < n; i++) begin
         j       = $urandom_range(0, n - 1);
         tmp_key = keys[i];
         keys[i] = keys[j];
         keys[j] = tmp_key;
         tmp_nul = nuls[i];
         nuls[i] = nuls[j];
         nuls[j] = tmp_nul;
      end
      if ($urandom_range(0, 9) == 0) foreach (nuls[i]) nuls[i] = 1'b1;
      if ($urandom_range(0, 4) != 0)
         offer(ACT_BUILD, {$urandom, $urandom}, 1'($urandom), 1'($urandom));
      for (int i = 0; i < n; i++)
         offer(ACT_MEASURE, with_junk(keys[i]), nuls[i], i == n - 1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 85)
            offer(ACT_INSERT, with_junk(keys[i]), nuls[i], i == n - 1);
      end
      if ($urandom_range(0, 4) == 0) begin
         offer(ACT_INSERT, with_junk(lo - 64'd1), 1'b0, 1'b0);
         offer(ACT_INSERT, with_junk(hi + 64'd1), 1'b0, 1'b1);
      end
      m = $urandom_range(3, 12);
      for (int i = 0; i < m; i++) begin
         case ($urandom_range(0, 5))
            0, 1: pick = keys[$urandom_range(0, n - 1)];
            2: pick = lo - 64'd1;
            3: pick = hi + 64'd1;
            4: pick = lo + ($urandom % (32'(hi - lo) + 1));
            default: pick = {$urandom, $urandom};
         endcase
         offer(ACT_PROBE, with_junk(pick), $urandom_range(0, 99) < 8, 1'($urandom));
      end
   endtask

   // Broken sequences: any action, any fields.
   task automatic noise_session();
      int          n;
      logic [63:0] key;
      n = $urandom_range(1, 6);
      repeat (n) begin
         if ($urandom_range(0, 1) != 0) key = {$urandom, $urandom};
         else key = with_junk(masked_key(64'($urandom_range(0, 300))));
         offer(action_type'($urandom_range(0, 3)), key,
               $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 30);
      end
   endtask

   // Directed items under the reset settings: 8-byte keys, offset on, full limit.
   plan_row_type directed_plan [25] = '{
      '{ACT_PROBE,   64'd5,  1'b0, 1'b0, 1'b1, 1'b0, ST_OK},    // nothing built yet
      '{ACT_INSERT,  64'd5,  1'b0, 1'b1, 1'b1, 1'b0, ST_OK},    // no filter, last ignored
      '{ACT_MEASURE, 64'd77, 1'b1, 1'b1, 1'b1, 1'b0, ST_OK},    // no keys: empty filter
      '{ACT_PROBE,   64'd0,  1'b0, 1'b0, 1'b1, 1'b0, ST_OK},    // empty filter misses
      '{ACT_BUILD,   K_TOP,  1'b0, 1'b1, 1'b1, 1'b0, ST_OK},
      '{ACT_MEASURE, K_TOP,  1'b0, 1'b0, 1'b1, 1'b0, ST_OK},
      '{ACT_MEASURE, K_LOW,  1'b0, 1'b1, 1'b0, 1'b0, ST_OK},
      '{ACT_INSERT,  K_TOP,  1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{ACT_INSERT,  K_LOW,  1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{ACT_INSERT,  K_MID,  1'b1, 1'b0, 1'b0, 1'b0, ST_OK},    // null key skipped
      '{ACT_INSERT,  64'd5,  1'b0, 1'b1, 1'b0, 1'b0, ST_OK},    // below the range
      '{ACT_PROBE,   K_TOP,  1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{ACT_PROBE,   K_LOW,  1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{ACT_PROBE,   K_MID,  1'b1, 1'b0, 1'b1, 1'b0, ST_OK},    // null probe misses
      '{ACT_PROBE,   K_MID,  1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{ACT_PROBE,   K_LOW - 64'd1, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{ACT_MEASURE, 64'd0,  1'b0, 1'b0, 1'b0, 1'b0, ST_OK},    // filter survives this
      '{ACT_PROBE,   K_TOP,  1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{ACT_MEASURE, 64'd5,  1'b0, 1'b1, 1'b1, 1'b0, ST_RANGE}, // span covers all keys
      '{ACT_PROBE,   K_TOP,  1'b0, 1'b0, 1'b1, 1'b0, ST_OK},    // failed build misses
      '{ACT_BUILD,   64'd0,  1'b0, 1'b0, 1'b1, 1'b0, ST_OK},
      '{ACT_MEASURE, 64'd0,  1'b0, 1'b1, 1'b0, 1'b0, ST_OK},
      '{ACT_INSERT,  64'd0,  1'b0, 1'b1, 1'b0, 1'b0, ST_OK},
      '{ACT_PROBE,   64'd0,  1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
      '{ACT_PROBE,   64'd1,  1'b0, 1'b0, 1'b0, 1'b0, ST_OK}
   };

   // Extremes of every register among them: widths 0, 15 and the invalid 3,
   // limits 0, 1 and the 17-bit maximum above the bitmap size.
   setting_row_type settings [12] = '{
      '{4'd1,  1'b1, 17'd65536},
      '{4'd2,  1'b0, 17'd65536},
      '{4'd4,  1'b1, 17'd300},
      '{4'd8,  1'b0, 17'd131071},
      '{4'd3,  1'b1, 17'd65536},
      '{4'd2,  1'b1, 17'd1},
      '{4'd8,  1'b1, 17'd0},
      '{4'd0,  1'b1, 17'd65536},
      '{4'd15, 1'b0, 17'd4096},
      '{4'd4,  1'b0, 17'd65536},
      '{4'd1,  1'b0, 17'd256},
      '{4'd8,  1'b1, 17'd64}
   };

   initial begin
      int target;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) offer_item(directed_plan[i]);

      target = sent_items;
      foreach (settings[p]) begin
         apply_setting(settings[p], p == 0);
         // back-pressure: hold the response side while items keep coming
         if (p == 1) hold_asks++;
         target += PHASE_ITEMS;
         while (sent_items < target - PHASE_ITEMS / 2) begin
            if ($urandom_range(0, 99) < 78) filter_session();
            else noise_session();
         end
         // pause the sender mid-phase until the block has caught up
         if (p == 2) drain();
         while (sent_items < target) begin
            if ($urandom_range(0, 99) < 78) filter_session();
            else noise_session();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("** offset_bitmap_filter_top: PASSED **");
      end else begin
         $display("** offset_bitmap_filter_top: FAILED **");
      end
      $finish;
   end

   // Watchdog: the normal run ends far sooner than this.
   initial begin
      #(WATCHDOG_NS);
      $display("** offset_bitmap_filter_top: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
src/obf_pkg.sv
src/obf_bitmap.sv
src/offset_bitmap_filter_top.sv
test/tb_offset_bitmap_filter_top.sv
